/* hw/rtl/mmdp_pkg.sv */
// ----------------------------------------------------------------------------
// mmdp_pkg
// Shared types and constants for the min/max decimation pyramid: default
// sizes, field widths, chain codes, controller states and control structs.
// ----------------------------------------------------------------------------
package mmdp_pkg;

	localparam int DEF_LEVELS      = 24;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_COUNT_BITS  = 32;

	// fixed widths of the result fields
	localparam int LEVEL_BITS = 5;
	localparam int CHAIN_BITS = 2;
	localparam int POS_BITS   = 32;

	localparam logic [CHAIN_BITS-1:0] CHAIN_RAW = 2'd0;
	localparam logic [CHAIN_BITS-1:0] CHAIN_MIN = 2'd1;
	localparam logic [CHAIN_BITS-1:0] CHAIN_MAX = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RAW,
		ST_MIN,
		ST_MAX
	} mmdp_state_t;

	// controller to datapath
	typedef struct packed {
		logic                  load;
		logic                  emit;
		logic [CHAIN_BITS-1:0] chain;
		logic                  last;
		logic                  advance;
		logic                  store;
		logic                  restart;
	} mmdp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic chain_end;
		logic top;
	} mmdp_sts_t;

endpackage

/* hw/rtl/mmdp_ctrl.sv */
// ----------------------------------------------------------------------------
// mmdp_ctrl
// Sequencer: takes a sample, issues the raw write, then walks the minimum
// and maximum chains level by level until the pair count is odd or at the top.
// ----------------------------------------------------------------------------
module mmdp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  mmdp_pkg::mmdp_sts_t sts,
	output mmdp_pkg::mmdp_cmd_t cmd
);
	import mmdp_pkg::*;

	mmdp_state_t state_q;
	mmdp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		cmd          = '0;
		cmd.chain    = CHAIN_RAW;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RAW;
				end
			end
			ST_RAW: begin
				cmd.chain = CHAIN_RAW;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.chain_end) begin
						// first half of a pair: keep it and finish
						cmd.store = 1'b1;
						cmd.last  = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_MIN;
					end
				end
			end
			ST_MIN: begin
				cmd.chain = CHAIN_MIN;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.chain_end) begin
						cmd.store   = !sts.top;
						cmd.restart = 1'b1;
						state_d     = ST_MAX;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			ST_MAX: begin
				cmd.chain = CHAIN_MAX;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.chain_end) begin
						cmd.store = !sts.top;
						cmd.last  = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/mmdp_datapath.sv */
// ----------------------------------------------------------------------------
// mmdp_datapath
// Sample counter, level walker, pending pair halves of both chains, the
// min/max accumulators and the result register.
// ----------------------------------------------------------------------------
module mmdp_datapath #(
	parameter int LEVELS      = mmdp_pkg::DEF_LEVELS,
	parameter int SAMPLE_BITS = mmdp_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = mmdp_pkg::DEF_COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  mmdp_pkg::mmdp_cmd_t                 cmd,
	output mmdp_pkg::mmdp_sts_t                 sts,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [mmdp_pkg::LEVEL_BITS-1:0]     level,
	output logic [mmdp_pkg::CHAIN_BITS-1:0]     chain,
	output logic [mmdp_pkg::POS_BITS-1:0]       position,
	output logic signed [SAMPLE_BITS-1:0]       value,
	output logic                                last
);
	import mmdp_pkg::*;

	localparam int LV_BITS  = $clog2(LEVELS + 1);
	localparam int IDX_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// entry 0 holds the pending raw sample, entry L the pending half at level L
	logic signed [SAMPLE_BITS-1:0] pend_min_q [LEVELS];
	logic signed [SAMPLE_BITS-1:0] pend_max_q [LEVELS];

	logic [COUNT_BITS-1:0]         count_q;
	logic [COUNT_BITS:0]           c_q;
	logic [COUNT_BITS:0]           sh_q;
	logic [LV_BITS-1:0]            lv_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [SAMPLE_BITS-1:0] acc_min_q;
	logic signed [SAMPLE_BITS-1:0] acc_max_q;
	logic                          out_valid_q;

	logic [IDX_BITS-1:0]                   idx;
	logic signed [SAMPLE_BITS-1:0]         rd_min;
	logic signed [SAMPLE_BITS-1:0]         rd_max;
	logic signed [SAMPLE_BITS-1:0]         min_a;
	logic signed [SAMPLE_BITS-1:0]         max_a;
	logic signed [SAMPLE_BITS-1:0]         min_new;
	logic signed [SAMPLE_BITS-1:0]         max_new;
	logic signed [SAMPLE_BITS-1:0]         emit_val;
	logic [COUNT_BITS:0]                   sh_m1;
	logic [POS_BITS+COUNT_BITS:0]          pos_wide;
	logic [LEVEL_BITS+LV_BITS-1:0]         lvl_wide;
	logic [COUNT_BITS:0]                   c_next;
	logic                                  top;

	assign idx    = lv_q[IDX_BITS-1:0];
	assign rd_min = pend_min_q[idx];
	assign rd_max = pend_max_q[idx];
	assign top    = (lv_q == LV_BITS'(LEVELS));

	// the raw level feeds both chains
	assign min_a   = (cmd.chain == CHAIN_RAW) ? s_q : acc_min_q;
	assign max_a   = (cmd.chain == CHAIN_RAW) ? s_q : acc_max_q;
	assign min_new = (min_a < rd_min) ? min_a : rd_min;
	assign max_new = (max_a > rd_max) ? max_a : rd_max;

	assign sh_m1    = sh_q - {{COUNT_BITS{1'b0}}, 1'b1};
	assign pos_wide = {{POS_BITS{1'b0}}, sh_m1};
	assign lvl_wide = {{LEVEL_BITS{1'b0}}, lv_q};
	assign c_next   = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1};

	always_comb begin
		case (cmd.chain)
			CHAIN_RAW: emit_val = s_q;
			CHAIN_MIN: emit_val = acc_min_q;
			default:   emit_val = acc_max_q;
		endcase
	end

	assign sts.out_free  = !out_valid_q || result_ready;
	assign sts.chain_end = sh_q[0] || top;
	assign sts.top       = top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= c_next[COUNT_BITS-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q  <= sample;
			c_q  <= c_next;
			sh_q <= c_next;
			lv_q <= '0;
		end else if (cmd.restart) begin
			sh_q <= c_q >> 1;
			lv_q <= LV_BITS'(1);
		end else if (cmd.advance) begin
			sh_q <= sh_q >> 1;
			lv_q <= lv_q + LV_BITS'(1);
		end
		if (cmd.advance) begin
			if (cmd.chain == CHAIN_RAW) begin
				acc_min_q <= min_new;
				acc_max_q <= max_new;
			end else if (cmd.chain == CHAIN_MIN) begin
				acc_min_q <= min_new;
			end else begin
				acc_max_q <= max_new;
			end
		end
		if (cmd.store) begin
			if (cmd.chain == CHAIN_RAW) begin
				pend_min_q[idx] <= s_q;
				pend_max_q[idx] <= s_q;
			end else if (cmd.chain == CHAIN_MIN) begin
				pend_min_q[idx] <= acc_min_q;
			end else begin
				pend_max_q[idx] <= acc_max_q;
			end
		end
		if (cmd.emit) begin
			level    <= lvl_wide[LEVEL_BITS-1:0];
			chain    <= cmd.chain;
			position <= pos_wide[POS_BITS-1:0];
			value    <= emit_val;
			last     <= cmd.last;
		end
	end

	assign result_valid = out_valid_q;

endmodule

/* hw/rtl/min_max_decimation_pyramid.sv */
// ----------------------------------------------------------------------------
// min_max_decimation_pyramid
// Builds a min/max decimation pyramid from a stream of signed samples and
// emits the buffer write commands that each sample causes.
// ----------------------------------------------------------------------------
// Each accepted sample produces one raw write at level 0 and, when it closes
// a pair, d writes down the minimum chain followed by d writes down the
// maximum chain, where d is the number of trailing zero bits of the new
// sample count (capped at LEVELS). The writes of a sample leave through a
// single result register at one per cycle while result_ready is held high.
// The sample is taken first, then its raw write goes out, then one write per
// chain level. The final write of a sample carries last, and the next
// sample is taken while that write is still waiting on result_ready.
module min_max_decimation_pyramid #(
	parameter int LEVELS      = mmdp_pkg::DEF_LEVELS,
	parameter int SAMPLE_BITS = mmdp_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = mmdp_pkg::DEF_COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [mmdp_pkg::LEVEL_BITS-1:0] level,
	output logic [mmdp_pkg::CHAIN_BITS-1:0] chain,
	output logic [mmdp_pkg::POS_BITS-1:0]   position,
	output logic signed [SAMPLE_BITS-1:0]   value,
	output logic                            last
);
	import mmdp_pkg::*;

	mmdp_cmd_t cmd;
	mmdp_sts_t sts;

	mmdp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	mmdp_datapath #(
		.LEVELS      (LEVELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.level        (level),
		.chain        (chain),
		.position     (position),
		.value        (value),
		.last         (last)
	);

endmodule

/* test/min_max_decimation_pyramid_tb.sv */
// ----------------------------------------------------------------------------
// min_max_decimation_pyramid_tb
// Drives signed samples into the pyramid and checks every write command that
// comes out, field by field and in order, against a behavioural model of the
// min/max reduction held in a small scoreboard. Both handshakes are throttled
// at random in the first two of three phases; the last runs unthrottled.
// ----------------------------------------------------------------------------
module min_max_decimation_pyramid_tb;
	import mmdp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS         = DEF_LEVELS;
	localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
	localparam int COUNT_BITS     = DEF_COUNT_BITS;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 2 * LEVELS + 16;
	localparam int RANDOM_PER_PHASE = 42;

	localparam logic [SAMPLE_BITS-1:0] OPENING[24] = '{
		16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
		16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h3039, 16'hCFC7,
		16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0064, 16'hFF9C,
		16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001, 16'h7FFE, 16'h8001
	};

	class pyramid_write_board;
		typedef struct {
			logic [LEVEL_BITS-1:0]         lvl;
			logic [CHAIN_BITS-1:0]         chn;
			logic [POS_BITS-1:0]           pos;
			logic signed [SAMPLE_BITS-1:0] val;
			logic                          lst;
		} write_cmd_t;

		logic [COUNT_BITS-1:0]         sample_count;
		logic signed [SAMPLE_BITS-1:0] pending_raw;
		logic signed [SAMPLE_BITS-1:0] pending_lo[LEVELS+1];
		logic signed [SAMPLE_BITS-1:0] pending_hi[LEVELS+1];
		write_cmd_t                    expected_writes[$];
		int                            mismatches;

		function new();
			sample_count = '0;
			mismatches   = 0;
		endfunction

		function void push_write(int lv, logic [CHAIN_BITS-1:0] chn,
				logic [POS_BITS-1:0] pos, logic signed [SAMPLE_BITS-1:0] val);
			write_cmd_t w;
			w.lvl = LEVEL_BITS'(lv);
			w.chn = chn;
			w.pos = pos;
			w.val = val;
			w.lst = 1'b0;
			expected_writes.push_back(w);
		endfunction

		// works out every write that one accepted sample causes
		function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
			logic [COUNT_BITS:0]           c;
			logic [COUNT_BITS:0]           idx;
			logic signed [SAMPLE_BITS-1:0] lo[LEVELS+1];
			logic signed [SAMPLE_BITS-1:0] hi[LEVELS+1];
			int                            depth;
			int                            lv;
			c     = {1'b0, sample_count} + 1'b1;
			depth = 0;
			push_write(0, CHAIN_RAW, POS_BITS'(sample_count), s);
			if (c[0]) begin
				pending_raw = s;
			end else begin
				lo[1] = (s < pending_raw) ? s : pending_raw;
				hi[1] = (s > pending_raw) ? s : pending_raw;
				// reduce downward while each level closes a pair
				for (lv = 1; lv < LEVELS && !c[lv]; lv++) begin
					lo[lv+1] = (lo[lv] < pending_lo[lv]) ? lo[lv] : pending_lo[lv];
					hi[lv+1] = (hi[lv] > pending_hi[lv]) ? hi[lv] : pending_hi[lv];
				end
				depth = lv;
				if (lv < LEVELS) begin
					pending_lo[lv] = lo[lv];
					pending_hi[lv] = hi[lv];
				end
			end
			for (lv = 1; lv <= depth; lv++) begin
				idx = (c >> lv) - 1'b1;
				push_write(lv, CHAIN_MIN, idx[POS_BITS-1:0], lo[lv]);
			end
			for (lv = 1; lv <= depth; lv++) begin
				idx = (c >> lv) - 1'b1;
				push_write(lv, CHAIN_MAX, idx[POS_BITS-1:0], hi[lv]);
			end
			expected_writes[expected_writes.size()-1].lst = 1'b1;
			sample_count = c[COUNT_BITS-1:0];
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_write(logic [LEVEL_BITS-1:0] lvl, logic [CHAIN_BITS-1:0] chn,
				logic [POS_BITS-1:0] pos, logic signed [SAMPLE_BITS-1:0] val,
				logic lst);
			write_cmd_t w;
			if (expected_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write level %0d chain %0d position %0d value %0d",
					lvl, chn, pos, val));
			end else begin
				w = expected_writes.pop_front();
				if (lvl !== w.lvl)
					report_mismatch($sformatf("level got %0d want %0d", lvl, w.lvl));
				if (chn !== w.chn)
					report_mismatch($sformatf("chain got %0d want %0d (level %0d)",
						chn, w.chn, w.lvl));
				if (pos !== w.pos)
					report_mismatch($sformatf("position got %0d want %0d (level %0d chain %0d)",
						pos, w.pos, w.lvl, w.chn));
				if (val !== w.val)
					report_mismatch($sformatf("value got %0d want %0d (level %0d chain %0d)",
						val, w.val, w.lvl, w.chn));
				if (lst !== w.lst)
					report_mismatch($sformatf("last got %0b want %0b (level %0d chain %0d)",
						lst, w.lst, w.lvl, w.chn));
			end
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          result_valid;
	logic                          result_ready;
	logic [LEVEL_BITS-1:0]         level;
	logic [CHAIN_BITS-1:0]         chain;
	logic [POS_BITS-1:0]           position;
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          last;

	int unsigned        src_idle_pct;
	int unsigned        sink_idle_pct;
	int unsigned        idle_cycles;
	pyramid_write_board board;

	min_max_decimation_pyramid dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.level        (level),
		.chain        (chain),
		.position     (position),
		.value        (value),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample       = s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		board.note_sample(s);
		@(negedge clk);
	endtask

	// receiver throttling
	always @(negedge clk) begin
		result_ready = ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_write(level, chain, position, value, last);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("min_max_decimation_pyramid test failed");
				$finish;
			end
		end
	end

	initial begin
		logic signed [SAMPLE_BITS-1:0] s;
		board         = new();
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		src_idle_pct  = 19;
		sink_idle_pct = 84;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (OPENING[i])
			send_sample(OPENING[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 19;
					sink_idle_pct = 84;
				end
				1: begin
					src_idle_pct  = 84;
					sink_idle_pct = 19;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				// mostly uniform values, now and then an extreme
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0:       s = 16'h8000;
						1:       s = 16'h7FFF;
						2:       s = 16'h0000;
						default: s = 16'hFFFF;
					endcase
				end else begin
					s = SAMPLE_BITS'($urandom);
				end
				send_sample(s);
			end
		end
		sample_valid = 1'b0;

		while (board.expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.expected_writes.size() == 0)
			$display("min_max_decimation_pyramid test passed");
		else
			$display("min_max_decimation_pyramid test failed");
		$finish;
	end

endmodule
